FILE: sv/rc_switch_record_debouncer_top_assert.svh
// Assertion macros for the record debouncer; they expand to nothing in synthesis.
// Each use assumes a clock named clk and a synchronous reset named rst in scope.
`ifndef RC_SWITCH_RECORD_DEBOUNCER_TOP_ASSERT_SVH
`define RC_SWITCH_RECORD_DEBOUNCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RCSD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcsd assertion failed");

// Next-cycle implication.
`define RCSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcsd assertion failed");

`else

`define RCSD_ASSERT_IMPLY(lbl, ante, cons)
`define RCSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/rcsd_pkg.sv
package rcsd_pkg;

  localparam int ThresholdW = 12;
  localparam int HoldW      = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIndexW  = 1;
  localparam int TimeW      = 32;

  // Item operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_DONE = 1'b1;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_LEVEL_THRESHOLD = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_HOLD_TIME_MS    = 1'b1;

  localparam logic [ThresholdW-1:0] LEVEL_THRESHOLD_RST = 12'd1700;
  localparam logic [HoldW-1:0]      HOLD_TIME_MS_RST    = 16'd200;

  // us -> ms: t / 1000 = (t >> 3) / 125, and (t >> 3) / 125 is exact as
  // ((t >> 3) * ceil(2^36 / 125)) >> 36 for every 29-bit operand.
  localparam int DivInW  = TimeW - 3;
  localparam int RecipW  = 30;
  localparam int MsShift = 36;
  localparam int ProdW   = DivInW + RecipW;
  localparam int NowMsW  = 23;   // 2^32 / 1000 fits in 23 bits
  localparam logic [RecipW-1:0] MS_RECIP = 30'd549755814;

  typedef struct packed {
    logic                  op;
    logic                  signal_present;
    logic [ThresholdW-1:0] channel_value;
    logic [TimeW-1:0]      time_us;
    logic                  transfer_ok;
  } rcsd_item_t;

  typedef struct packed {
    logic send_request;
    logic send_record;
    logic record_indicator;
  } rcsd_result_t;

  // Item after the time has been turned into milliseconds
  typedef struct packed {
    logic                  op;
    logic                  signal_present;
    logic [ThresholdW-1:0] channel_value;
    logic [NowMsW-1:0]     now_ms;
    logic                  transfer_ok;
  } rcsd_tick_t;

endpackage

FILE: sv/rcsd_state.sv
`include "rc_switch_record_debouncer_top_assert.svh"

module rcsd_state
  import rcsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  upd,
  input  rcsd_tick_t            tick,
  input  logic [ThresholdW-1:0] level_threshold,
  input  logic [HoldW-1:0]      hold_time_ms,
  output rcsd_result_t          res
);

  logic              confirmed_level, confirmed_level_next;
  logic              pending_flag, pending_flag_next;
  logic              pending_level, pending_level_next;
  logic [NowMsW-1:0] change_time_ms, change_time_ms_next;
  logic              commanded_record, commanded_record_next;
  logic              requested_record, requested_record_next;

  logic            lvl;
  logic [NowMsW:0] diff;
  logic            held;
  logic            req;
  logic            rec;

  assign lvl = tick.channel_value > level_threshold;

  // Time stepping backwards borrows: the 32-bit wrapped gap is then huge, so confirm.
  assign diff = {1'b0, tick.now_ms} - {1'b0, change_time_ms};
  assign held = diff[NowMsW] ||
                (diff[NowMsW-1:0] >= {{(NowMsW-HoldW){1'b0}}, hold_time_ms});

  always_comb begin
    confirmed_level_next  = confirmed_level;
    pending_flag_next     = pending_flag;
    pending_level_next    = pending_level;
    change_time_ms_next   = change_time_ms;
    commanded_record_next = commanded_record;
    requested_record_next = requested_record;
    req = 1'b0;
    rec = 1'b0;
    case (tick.op)
      OP_DONE: begin
        if (tick.transfer_ok) begin
          commanded_record_next = requested_record;
        end
      end
      OP_TICK: begin
        if (!tick.signal_present) begin
          if (commanded_record) begin
            req = 1'b1;
            requested_record_next = 1'b0;
          end
          pending_flag_next    = 1'b0;
          confirmed_level_next = 1'b0;
        end else if (lvl != confirmed_level) begin
          if (!pending_flag || (pending_level != lvl)) begin
            pending_flag_next   = 1'b1;
            pending_level_next  = lvl;
            change_time_ms_next = tick.now_ms;
          end else if (held) begin
            confirmed_level_next = lvl;
            pending_flag_next    = 1'b0;
            if (lvl != commanded_record) begin
              req = 1'b1;
              rec = lvl;
              requested_record_next = lvl;
            end
          end
        end else begin
          pending_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.send_request     = req;
  assign res.send_record      = rec;
  assign res.record_indicator = commanded_record_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      confirmed_level  <= 1'b0;
      pending_flag     <= 1'b0;
      pending_level    <= 1'b0;
      change_time_ms   <= '0;
      commanded_record <= 1'b0;
      requested_record <= 1'b0;
    end else if (upd) begin
      confirmed_level  <= confirmed_level_next;
      pending_flag     <= pending_flag_next;
      pending_level    <= pending_level_next;
      change_time_ms   <= change_time_ms_next;
      commanded_record <= commanded_record_next;
      requested_record <= requested_record_next;
    end
  end

  // A pending change always targets the other level.
  `RCSD_ASSERT_IMPLY(a_pending_differs, pending_flag, pending_level != confirmed_level)
  // A successful done report takes over the requested state.
  `RCSD_ASSERT_NEXT(a_done_commits, upd && (tick.op == OP_DONE) && tick.transfer_ok, commanded_record == $past(requested_record))
  // Loss of signal clears the debounce state.
  `RCSD_ASSERT_NEXT(a_loss_clears, upd && (tick.op == OP_TICK) && !tick.signal_present, !confirmed_level && !pending_flag)
  // With signal present, a request only follows a fresh confirmation.
  `RCSD_ASSERT_NEXT(a_req_on_confirm, upd && (tick.op == OP_TICK) && tick.signal_present && req, confirmed_level != $past(confirmed_level))

endmodule

FILE: sv/rc_switch_record_debouncer_top.sv
// RC switch record debouncer. Each item is either a sample tick (op = OP_TICK) carrying the
// signal-present flag, the selected channel value and a 32-bit microsecond time, or a transfer
// done report (op = OP_DONE) carrying transfer_ok. Every item yields exactly one result:
// send_request/send_record ask for a record (1) or stop (0) command, and record_indicator shows
// the last successfully commanded state. A channel value above level_threshold means record; a
// new level must persist for hold_time_ms milliseconds before it is confirmed, and a command is
// asked for only when the confirmed level differs from the commanded one. Loss of signal asks
// for a stop while recording and clears the debounce state. The block takes one item per clock
// while item_stall is low. The accepting edge registers the item, the microsecond-to-millisecond
// reciprocal multiply is then registered in stage two, and the state update is loaded into the
// result register. Both channels use valid/stall; a stalled result stage still lets earlier
// stages fill. Write level_threshold (index REG_LEVEL_THRESHOLD) and hold_time_ms
// (REG_HOLD_TIME_MS) through wr_en/wr_index/wr_data only while no item is in flight.
module rc_switch_record_debouncer_top
  import rcsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  rcsd_item_t           item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output rcsd_result_t         result
);

  logic [ThresholdW-1:0] level_threshold;
  logic [HoldW-1:0]      hold_time_ms;

  // pipeline stages
  logic         s1_valid;
  rcsd_item_t   s1;
  logic         s2_valid;
  rcsd_tick_t   s2;
  logic         rdy1, rdy2, rdy3;
  logic         upd;
  logic [ProdW-1:0] prod;
  rcsd_result_t res;

  // Configuration registers: hold value until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= LEVEL_THRESHOLD_RST;
      hold_time_ms    <= HOLD_TIME_MS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEVEL_THRESHOLD: level_threshold <= wr_data[ThresholdW-1:0];
        REG_HOLD_TIME_MS:    hold_time_ms    <= wr_data[HoldW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each stage advances when empty or when the stage after it advances, so bubbles collapse
  // and a waiting result does not block the earlier stages.
  assign rdy3       = !result_valid || !result_stall;
  assign rdy2       = !s2_valid || rdy3;
  assign rdy1       = !s1_valid || rdy2;
  assign item_stall = !rdy1;
  assign upd        = rdy3 && s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= item_valid;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
      if (rdy3) begin
        result_valid <= s2_valid;
      end
    end
  end

  // Milliseconds from microseconds: drop three bits, then divide by 125 via the reciprocal.
  assign prod = {{RecipW{1'b0}}, s1.time_us[TimeW-1:3]} * {{DivInW{1'b0}}, MS_RECIP};

  always_ff @(posedge clk) begin
    if (rdy1 && item_valid) begin
      s1 <= item;
    end
    if (rdy2 && s1_valid) begin
      s2.op             <= s1.op;
      s2.signal_present <= s1.signal_present;
      s2.channel_value  <= s1.channel_value;
      s2.now_ms         <= prod[MsShift +: NowMsW];
      s2.transfer_ok    <= s1.transfer_ok;
    end
    if (upd) begin
      result <= res;
    end
  end

  // Debounce and command state; advances once per item leaving stage two.
  rcsd_state u_state (
    .clk             (clk),
    .rst             (rst),
    .upd             (upd),
    .tick            (s2),
    .level_threshold (level_threshold),
    .hold_time_ms    (hold_time_ms),
    .res             (res)
  );

endmodule

FILE: tb/rc_switch_record_debouncer_top_tb.sv
`timescale 1ns / 100ps

module rc_switch_record_debouncer_top_tb;
  import rcsd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int MaxReported = 10;
  // pipeline is three stages deep; leave some margin before register writes
  localparam int DrainCycles = 8;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 wr_en        = 1'b0;
  logic [CfgIndexW-1:0] wr_index     = '0;
  logic [CfgDataW-1:0]  wr_data      = '0;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  rcsd_item_t           item_bus     = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  rcsd_result_t         result_bus;

  rc_switch_record_debouncer_top dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_bus)
  );

  always #5 clk = ~clk;

  // Debouncer state as predicted by the testbench
  logic [ThresholdW-1:0] cfg_threshold = LEVEL_THRESHOLD_RST;
  logic [HoldW-1:0]      cfg_hold      = HOLD_TIME_MS_RST;
  logic                  stable_level  = 1'b0;
  logic                  change_seen   = 1'b0;
  logic                  change_level  = 1'b0;
  logic [TimeW-1:0]      change_ms     = '0;
  logic                  cmd_record    = 1'b0;
  logic                  asked_record  = 1'b0;

  rcsd_result_t switch_cmd_q[$];
  rcsd_result_t last_cmd = '0;
  rcsd_result_t want_cmd;

  int          mismatches  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          idle_on     = 1'b0;
  bit          stall_on    = 1'b0;
  logic        target_high = 1'b0;
  logic [31:0] now_us      = '0;

  // Work out the command and indicator one item causes, and advance the state
  function automatic rcsd_result_t predict_switch_cmd(rcsd_item_t it);
    rcsd_result_t     r;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] elapsed;
    logic             lvl;
    r = '0;
    if (it.op == OP_DONE) begin
      if (it.transfer_ok) cmd_record = asked_record;
    end else if (!it.signal_present) begin
      if (cmd_record) begin
        r.send_request = 1'b1;
        r.send_record  = 1'b0;
        asked_record   = 1'b0;
      end
      change_seen  = 1'b0;
      stable_level = 1'b0;
    end else begin
      now_ms = it.time_us / 32'd1000;
      lvl    = it.channel_value > cfg_threshold;
      if (lvl != stable_level) begin
        elapsed = now_ms - change_ms;
        if (!change_seen || change_level != lvl) begin
          change_seen  = 1'b1;
          change_level = lvl;
          change_ms    = now_ms;
        end else if (elapsed >= TimeW'(cfg_hold)) begin
          stable_level = lvl;
          change_seen  = 1'b0;
          if (stable_level != cmd_record) begin
            r.send_request = 1'b1;
            r.send_record  = stable_level;
            asked_record   = stable_level;
          end
        end
      end else begin
        change_seen = 1'b0;
      end
    end
    r.record_indicator = cmd_record;
    return r;
  endfunction

  // Mostly no gap, sometimes a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic rcsd_item_t tick_item(logic sig, logic [ThresholdW-1:0] chan,
                                           logic [TimeW-1:0] t_us);
    rcsd_item_t it;
    it.op             = OP_TICK;
    it.signal_present = sig;
    it.channel_value  = chan;
    it.time_us        = t_us;
    it.transfer_ok    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Done report; the tick fields are filled with noise
  function automatic rcsd_item_t done_item(logic ok);
    rcsd_item_t it;
    it.op             = OP_DONE;
    it.signal_present = 1'($urandom_range(0, 1));
    it.channel_value  = ThresholdW'($urandom_range(0, 4095));
    it.time_us        = $urandom;
    it.transfer_ok    = ok;
    return it;
  endfunction

  // Offer one item, hold it until taken, then log what it should produce.
  // Handshake signals are sampled at the falling edge, where they are settled
  // for the rising edge that follows.
  task automatic send_item(input rcsd_item_t it);
    int   gap;
    logic stalled;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_bus   <= it;
    do begin
      @(negedge clk);
      stalled = item_stall;
      @(posedge clk);
    end while (stalled);
    last_cmd = predict_switch_cmd(it);
    switch_cmd_q.push_back(last_cmd);
  endtask

  // Stop offering items until every expected result is back
  task automatic wait_results_drained();
    item_valid <= 1'b0;
    while (switch_cmd_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_LEVEL_THRESHOLD) cfg_threshold = val[ThresholdW-1:0];
    else cfg_hold = val[HoldW-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] hold);
    wait_results_drained();
    write_reg(REG_LEVEL_THRESHOLD, thr);
    write_reg(REG_HOLD_TIME_MS, hold);
  endtask

  // Switch traffic: mostly steady time with a level that holds or flips,
  // done reports answering requests, plus signal loss and time jumps as noise
  task automatic send_traffic(input int n);
    int               r;
    int unsigned      step_ms;
    logic [ThresholdW-1:0] chan;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (last_cmd.send_request && $urandom_range(0, 3) != 0) begin
        send_item(done_item($urandom_range(0, 4) != 0));
      end else if (r < 8) begin
        send_item(done_item(1'($urandom_range(0, 1))));
      end else if (r < 14) begin
        send_item(tick_item(1'b0, ThresholdW'($urandom_range(0, 4095)), $urandom));
      end else if (r < 18) begin
        now_us = $urandom;
        send_item(tick_item(1'b1, ThresholdW'($urandom_range(0, 4095)), now_us));
      end else begin
        if ($urandom_range(0, 99) < 15) target_high = ~target_high;
        if (target_high && cfg_threshold != 12'hFFF)
          chan = ThresholdW'($urandom_range(int'(cfg_threshold) + 1, 4095));
        else if (target_high)
          chan = ThresholdW'($urandom_range(0, 4095));
        else
          chan = ThresholdW'($urandom_range(0, int'(cfg_threshold)));
        r = $urandom_range(0, 99);
        if (r < 60) step_ms = $urandom_range(0, cfg_hold / 3);
        else if (r < 90) step_ms = $urandom_range(cfg_hold, cfg_hold + cfg_hold / 4 + 2);
        else step_ms = $urandom_range(0, 3);
        now_us = now_us + step_ms * 1000 + $urandom_range(0, 999);
        send_item(tick_item(1'b1, chan, now_us));
      end
    end
  endtask

  // Hold times, threshold edges, signal loss, time wrap, done reports
  // with and without a request, and ticks while a transfer is in flight
  task automatic test_directed_cases();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_item(tick_item(1'b1, 12'd1701, 32'd0));
    send_item(tick_item(1'b1, 12'd1701, 32'd199_999));
    send_item(tick_item(1'b1, 12'd1701, 32'd200_000));
    send_item(done_item(1'b0));
    send_item(done_item(1'b1));
    send_item(tick_item(1'b1, 12'd1700, 32'd300_000));
    send_item(tick_item(1'b1, 12'd4095, 32'd310_000));
    send_item(tick_item(1'b1, 12'd0, 32'd320_000));
    send_item(tick_item(1'b1, 12'd0, 32'd519_999));
    send_item(tick_item(1'b1, 12'd0, 32'd520_000));
    // stop still outstanding: level goes back up and time runs backwards
    send_item(tick_item(1'b1, 12'd4095, 32'd521_000));
    send_item(tick_item(1'b1, 12'd4095, 32'd0));
    send_item(done_item(1'b1));
    send_item(tick_item(1'b0, 12'd4095, 32'hFFFF_FFFF));
    send_item(tick_item(1'b1, 12'd4095, 32'hFFFF_FFFF));
    send_item(tick_item(1'b1, 12'd4095, 32'd1000));
    send_item(tick_item(1'b0, 12'd0, 32'd0));
    send_item(done_item(1'b1));
    send_item(tick_item(1'b0, 12'd2048, 32'd12345));
    send_item(tick_item(1'b0, 12'd0, 32'd0));
    send_item(done_item(1'b0));
    send_item(done_item(1'b1));
    send_item(done_item(1'b1));
  endtask

  // Run traffic at every corner of threshold and hold time
  task automatic test_register_extremes();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    set_config(16'd0, 16'd0);
    send_traffic(20);
    set_config(16'd4095, 16'd65535);
    send_traffic(20);
    set_config(16'd0, 16'd65535);
    send_traffic(20);
    set_config(16'd4095, 16'd0);
    send_traffic(20);
  endtask

  task automatic test_random_traffic();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    set_config(LEVEL_THRESHOLD_RST, HOLD_TIME_MS_RST);
    send_traffic(100);
    idle_on  = 1'b1;
    stall_on = 1'b1;
    for (int p = 0; p < 4; p++) begin
      // upper data bits above the threshold width are noise
      set_config(CfgDataW'($urandom_range(0, 65535)),
                 ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, 65535))
                                             : CfgDataW'($urandom_range(0, 1000)));
      if (p == 1) begin
        send_traffic(35);
        wait_results_drained();
        send_traffic(40);
      end else begin
        send_traffic(75);
      end
    end
  endtask

  // Receiver back-pressure: random stalls of mixed length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      result_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each result taken at the next rising edge with the oldest expectation
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (switch_cmd_q.size() == 0) begin
        if (mismatches < MaxReported)
          $display("unexpected result: req=%0b rec=%0b ind=%0b", result_bus.send_request,
                   result_bus.send_record, result_bus.record_indicator);
        mismatches++;
      end else begin
        want_cmd = switch_cmd_q.pop_front();
        if (result_bus.send_request !== want_cmd.send_request ||
            result_bus.send_record !== want_cmd.send_record ||
            result_bus.record_indicator !== want_cmd.record_indicator) begin
          if (mismatches < MaxReported)
            $display("mismatch: expected req=%0b rec=%0b ind=%0b, got req=%0b rec=%0b ind=%0b",
                     want_cmd.send_request, want_cmd.send_record, want_cmd.record_indicator,
                     result_bus.send_request, result_bus.send_record,
                     result_bus.record_indicator);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("** rc_switch_record_debouncer_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && switch_cmd_q.size() == 0)
      $display("** rc_switch_record_debouncer_top: PASSED **");
    else
      $display("** rc_switch_record_debouncer_top: FAILED **");
    $finish;
  end

endmodule
